// File: rtl/tcq_pkg.sv
// tcq_pkg: shared types and constants for the two-class age-ordered queue.
// Command modes, result status codes, class codes, FIFO status struct.
// No dependencies.
`timescale 1ns / 1ps

package tcq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned HANDLE_BITS_DEF = 16;

  localparam logic [1:0] CLASS0 = 2'd0;
  localparam logic [1:0] CLASS1 = 2'd1;

  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_DEQ_ANY = 2'd1,
    MODE_DEQ_C0 = 2'd2,
    MODE_DEQ_C1 = 2'd3
  } tcq_mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BOTH_EMPTY = 2'd1,
    ST_CLASS_EMPTY = 2'd2,
    ST_FULL       = 2'd3
  } tcq_status_e;

  typedef struct packed {
    logic empty;
    logic single;
    logic full;
  } tcq_fifo_stat_t;

endpackage

// File: rtl/tcq_cmd_if.sv
// tcq_cmd_if: command channel (valid/ready plus command payload).
// Depends on tcq_pkg for the default handle width.
`timescale 1ns / 1ps

interface tcq_cmd_if #(
  parameter int unsigned HANDLE_BITS = tcq_pkg::HANDLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  logic [1:0]             item_class;
  logic [HANDLE_BITS-1:0] item_handle;

  modport source (output valid, mode, item_class, item_handle, input ready);
  modport sink   (input valid, mode, item_class, item_handle, output ready);
endinterface

// File: rtl/tcq_rsp_if.sv
// tcq_rsp_if: result channel (valid/ready plus result payload).
// Depends on tcq_pkg for the default handle width.
`timescale 1ns / 1ps

interface tcq_rsp_if #(
  parameter int unsigned HANDLE_BITS = tcq_pkg::HANDLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [HANDLE_BITS-1:0] out_handle;
  logic                   out_class;
  logic                   all_empty;

  modport source (output valid, status, out_handle, out_class, all_empty, input ready);
  modport sink   (input valid, status, out_handle, out_class, all_empty, output ready);
endinterface

// File: rtl/tcq_ram.sv
// tcq_ram: generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents.
`timescale 1ns / 1ps

module tcq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tcq_fifo.sv
// tcq_fifo: one class FIFO with head entry always presented (show-ahead).
// Uses tcq_ram for storage and tcq_pkg for the status struct.
`timescale 1ns / 1ps

module tcq_fifo #(
  parameter int unsigned WIDTH = 22,
  parameter int unsigned DEPTH = tcq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [WIDTH-1:0]        push_data_i,
  input  logic                    pop_i,
  output logic [WIDTH-1:0]        head_o,
  output tcq_pkg::tcq_fifo_stat_t stat_o
);
  import tcq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [AW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]    count_q, count_d;
  logic             byp_q, byp_d;
  logic [WIDTH-1:0] byp_data_q;
  logic [WIDTH-1:0] rdata;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (pop_i) begin
      head_d = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
    end
    if (push_i) begin
      tail_d = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  // write landing on the entry being fetched: forward it past the RAM
  assign byp_d = push_i && (tail_q == head_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      byp_q   <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= push_data_i;
  end

  tcq_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_i),
    .waddr_i (tail_q),
    .wdata_i (push_data_i),
    .raddr_i (head_d),
    .rdata_o (rdata)
  );

  assign head_o       = byp_q ? byp_data_q : rdata;
  assign stat_o.empty  = (count_q == '0);
  assign stat_o.single = (count_q == CW'(1));
  assign stat_o.full   = (count_q == CW'(DEPTH));

endmodule

// File: rtl/two_class_age_ordered_queue.sv
// two_class_age_ordered_queue: two class FIFOs sharing one arrival stamp counter.
// Depends on tcq_pkg, tcq_cmd_if, tcq_rsp_if, tcq_fifo (which uses tcq_ram).
//
//   channel  dir  signals                                   accepted when
//   cmd_i    in   mode, item_class, item_handle             valid && ready
//   rsp_o    out  status, out_handle, out_class, all_empty  valid && ready
//
// One command per cycle while cmd_i.ready is high; its result appears in the output register in
// the cycle after acceptance. The head compare and select run from the FIFO head
// registers straight into the result register.
// Reset clears pointers, counts, the stamp counter and the result valid.
// cmd_i.ready drops only while a result is held and rsp_o.ready is low.
`timescale 1ns / 1ps

module two_class_age_ordered_queue #(
  parameter int unsigned QUEUE_DEPTH = tcq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = tcq_pkg::HANDLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcq_cmd_if.sink    cmd_i,
  tcq_rsp_if.source  rsp_o
);
  import tcq_pkg::*;

  localparam int unsigned STAMP_MOD = 4 * QUEUE_DEPTH;
  localparam int unsigned SW        = $clog2(STAMP_MOD);
  localparam int unsigned EW        = HANDLE_BITS + SW;

  logic             acc;
  tcq_mode_e        mode;
  logic [SW-1:0]    arr_q, arr_d;
  logic             push0, push1, pop0, pop1;
  logic [EW-1:0]    head0, head1, push_data;
  tcq_fifo_stat_t   st0, st1;
  logic [SW-1:0]    s0, s1;
  logic [SW:0]      stamp_gap;
  logic             older0;
  tcq_status_e      status_d;
  logic [HANDLE_BITS-1:0] handle_d;
  logic             class_d, all_empty_d;
  logic             e0_next, e1_next;

  logic             rsp_valid_q;
  tcq_status_e      status_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic             class_q, all_empty_q;

  assign cmd_i.ready = !rsp_valid_q || rsp_o.ready;
  assign acc         = cmd_i.valid && cmd_i.ready;
  assign mode        = tcq_mode_e'(cmd_i.mode);
  assign push_data   = {cmd_i.item_handle, arr_q};

  assign s0 = head0[SW-1:0];
  assign s1 = head1[SW-1:0];

  // stamp distance modulo STAMP_MOD
  always_comb begin
    if (s0 >= s1) begin
      stamp_gap = {1'b0, s0} - {1'b0, s1};
    end else begin
      stamp_gap = {1'b0, s0} + (SW + 1)'(STAMP_MOD) - {1'b0, s1};
    end
  end
  assign older0 = (stamp_gap >= (SW + 1)'(STAMP_MOD / 2));

  always_comb begin
    push0    = 1'b0;
    push1    = 1'b0;
    pop0     = 1'b0;
    pop1     = 1'b0;
    status_d = ST_OK;
    handle_d = '0;
    class_d  = 1'b0;
    case (mode)
      MODE_ENQ: begin
        if (cmd_i.item_class == CLASS0) begin
          if (st0.full) status_d = ST_FULL;
          else          push0    = acc;
        end else if (cmd_i.item_class == CLASS1) begin
          if (st1.full) status_d = ST_FULL;
          else          push1    = acc;
        end
      end
      MODE_DEQ_ANY: begin
        if (st0.empty && st1.empty) begin
          status_d = ST_BOTH_EMPTY;
        end else if (st1.empty || (!st0.empty && older0)) begin
          pop0     = acc;
          handle_d = head0[EW-1:SW];
        end else begin
          pop1     = acc;
          handle_d = head1[EW-1:SW];
          class_d  = 1'b1;
        end
      end
      MODE_DEQ_C0: begin
        if (st0.empty) begin
          status_d = ST_CLASS_EMPTY;
        end else begin
          pop0     = acc;
          handle_d = head0[EW-1:SW];
        end
      end
      MODE_DEQ_C1: begin
        if (st1.empty) begin
          status_d = ST_CLASS_EMPTY;
        end else begin
          pop1     = acc;
          handle_d = head1[EW-1:SW];
          class_d  = 1'b1;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  assign e0_next     = (st0.empty && !push0) || (st0.single && pop0);
  assign e1_next     = (st1.empty && !push1) || (st1.single && pop1);
  assign all_empty_d = e0_next && e1_next;

  always_comb begin
    arr_d = arr_q;
    if (push0 || push1) begin
      arr_d = (arr_q == SW'(STAMP_MOD - 1)) ? '0 : arr_q + 1'b1;
    end
  end

  tcq_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo0 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push0),
    .push_data_i (push_data),
    .pop_i       (pop0),
    .head_o      (head0),
    .stat_o      (st0)
  );

  tcq_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push1),
    .push_data_i (push_data),
    .pop_i       (pop1),
    .head_o      (head1),
    .stat_o      (st1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      arr_q <= arr_d;
      if (acc) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q    <= status_d;
      handle_q    <= handle_d;
      class_q     <= class_d;
      all_empty_q <= all_empty_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.out_handle = handle_q;
  assign rsp_o.out_class  = class_q;
  assign rsp_o.all_empty  = all_empty_q;

  a_arr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arr_q <= SW'(STAMP_MOD - 1))
    else $error("stamp counter out of range");

  a_all_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (rsp_o.all_empty == (st0.empty && st1.empty)))
    else $error("all_empty disagrees with FIFO state");

  a_deq_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && mode != MODE_ENQ && !st0.empty && !st1.empty) |=> (rsp_o.status == ST_OK))
    else $error("dequeue failed with both queues holding items");

  a_zero_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_OK) |-> (rsp_o.out_handle == '0 && !rsp_o.out_class))
    else $error("non-ok result carries a handle");

endmodule
